/* design/cdq_pkg.sv */
// cdq_pkg: types, codes and constants shared by the circular deque core.
// Used by cdq_ram and circular_deque_core; depends on nothing else.
package cdq_pkg;

    localparam int CDQ_DEPTH = 1024;
    localparam int ENTRY_W   = 64;
    localparam int FILL_W    = 11;

    typedef enum logic [2:0] {
        MODE_INS_FRONT = 3'd0,
        MODE_INS_REAR  = 3'd1,
        MODE_REM_FRONT = 3'd2,
        MODE_REM_REAR  = 3'd3,
        MODE_PEEK      = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] in_x_pos;
        logic [15:0] in_y_pos;
        logic [15:0] in_dir;
        logic [15:0] in_sprite;
    } t_in_word;

    typedef struct packed {
        logic [15:0]       out_x_pos;
        logic [15:0]       out_y_pos;
        logic [15:0]       out_dir;
        logic [15:0]       out_sprite;
        logic [1:0]        status;
        logic              is_empty;
        logic              is_full;
        logic [FILL_W-1:0] fill_count;
    } t_out_word;

    // Result of one request held in the pending stage while any memory read is in flight
    typedef struct packed {
        logic [1:0]        status;
        logic              is_empty;
        logic              is_full;
        logic [FILL_W-1:0] fill_count;
        logic              use_data;
    } t_pend;

endpackage

/* design/circular_deque_core.sv */
// circular_deque_core: double-ended queue of DEPTH four-field entries in a ring.
// Depends on cdq_pkg and cdq_ram.
//
// Input channel (i_valid / o_ready / i_data) carries one request word: insert
// front, insert rear, remove front, remove rear or peek front. Output channel
// (o_valid / i_ready / o_data) returns exactly one result word per request:
// the removed or peeked entry (zero otherwise), a status code, the empty and
// full flags and the fill count after the request.
// Pointers, count and empty flag update in the accept cycle; inserts write the
// entry store then. Removes and peeks read the store, whose registered read data
// comes back alongside the pending stage; both then pass into the output register.
// Each result passes through the pending stage and then the output register,
// and o_valid rises once the result is in the output register.
// Throughput: one request per cycle while the receiver keeps up; the single
// read port of the store and the one-deep pending stage set that figure.
// When the receiver stalls, one more request is taken into the pending stage
// and o_ready then drops until the output register drains.
// Reset (synchronous, active low) empties the deque and clears both valid
// flags; o_ready is held low while reset is asserted. The entry store is not
// cleared and needs no clearing pass.
module circular_deque_core #(
    parameter int DEPTH = cdq_pkg::CDQ_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  cdq_pkg::t_in_word i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output cdq_pkg::t_out_word o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic          r_empty, n_empty;

    logic           r_pend_valid;
    cdq_pkg::t_pend r_pend, n_pend;
    logic               r_out_valid;
    cdq_pkg::t_out_word r_out;

    logic                        w_accept, w_move;
    logic                        w_we, w_re;
    logic [AW-1:0]               w_waddr, w_raddr;
    logic [cdq_pkg::ENTRY_W-1:0] w_wdata, w_rdata;
    logic [1:0]                  w_status;
    logic [31:0]                 w_cnt_ext;
    logic                        w_full_now;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
        return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
        return (i == '0) ? AW'(DEPTH - 1) : i - 1'b1;
    endfunction

    assign w_move   = r_pend_valid & (~r_out_valid | i_ready);
    assign o_ready  = i_rst_n & (~r_pend_valid | w_move);
    assign w_accept = i_valid & o_ready;
    assign w_full_now = (r_count == CW'(DEPTH));
    assign w_wdata  = {i_data.in_x_pos, i_data.in_y_pos, i_data.in_dir, i_data.in_sprite};

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_empty  = r_empty;
        w_we     = 1'b0;
        w_re     = 1'b0;
        w_waddr  = r_head;
        w_raddr  = r_head;
        w_status = cdq_pkg::ST_DONE;
        n_pend   = '0;
        case (i_data.mode)
            cdq_pkg::MODE_INS_FRONT, cdq_pkg::MODE_INS_REAR: begin
                if (w_full_now) begin
                    w_status = cdq_pkg::ST_FULL;
                end else if (r_empty) begin
                    // empty deque restarts at index zero
                    n_head  = '0;
                    n_tail  = '0;
                    n_empty = 1'b0;
                    n_count = CW'(1);
                    w_we    = 1'b1;
                    w_waddr = '0;
                end else if (i_data.mode == cdq_pkg::MODE_INS_FRONT) begin
                    n_head  = ring_prev(r_head);
                    n_count = r_count + 1'b1;
                    w_we    = 1'b1;
                    w_waddr = ring_prev(r_head);
                end else begin
                    n_tail  = ring_next(r_tail);
                    n_count = r_count + 1'b1;
                    w_we    = 1'b1;
                    w_waddr = ring_next(r_tail);
                end
            end
            cdq_pkg::MODE_REM_FRONT, cdq_pkg::MODE_REM_REAR, cdq_pkg::MODE_PEEK: begin
                if (r_empty) begin
                    w_status = cdq_pkg::ST_EMPTY;
                end else begin
                    w_re            = 1'b1;
                    n_pend.use_data = 1'b1;
                    w_raddr = (i_data.mode == cdq_pkg::MODE_REM_REAR) ? r_tail : r_head;
                    if (i_data.mode != cdq_pkg::MODE_PEEK) begin
                        n_count = r_count - 1'b1;
                        if (r_head == r_tail) begin
                            n_empty = 1'b1;
                        end else if (i_data.mode == cdq_pkg::MODE_REM_FRONT) begin
                            n_head = ring_next(r_head);
                        end else begin
                            n_tail = ring_prev(r_tail);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        w_cnt_ext         = 32'(n_count);
        n_pend.status     = w_status;
        n_pend.is_empty   = n_empty;
        n_pend.is_full    = (n_count == CW'(DEPTH));
        n_pend.fill_count = w_cnt_ext[cdq_pkg::FILL_W-1:0];
    end

    cdq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we & w_accept),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re & w_accept),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_empty      <= 1'b1;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_head       <= n_head;
                r_tail       <= n_tail;
                r_count      <= n_count;
                r_empty      <= n_empty;
                r_pend_valid <= 1'b1;
            end else if (w_move) begin
                r_pend_valid <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pend <= n_pend;
        end
        if (w_move) begin
            r_out.out_x_pos  <= r_pend.use_data ? w_rdata[63:48] : '0;
            r_out.out_y_pos  <= r_pend.use_data ? w_rdata[47:32] : '0;
            r_out.out_dir    <= r_pend.use_data ? w_rdata[31:16] : '0;
            r_out.out_sprite <= r_pend.use_data ? w_rdata[15:0]  : '0;
            r_out.status     <= r_pend.status;
            r_out.is_empty   <= r_pend.is_empty;
            r_out.is_full    <= r_pend.is_full;
            r_out.fill_count <= r_pend.fill_count;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count beyond depth");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty == (r_count == '0))
        else $error("empty flag and count disagree");

    a_full_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_full_now && (i_data.mode == cdq_pkg::MODE_INS_FRONT ||
         i_data.mode == cdq_pkg::MODE_INS_REAR))
        |=> (r_pend.status == cdq_pkg::ST_FULL && $stable(r_count)))
        else $error("insert into full deque not refused");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_valid && r_out_valid && !i_ready) |-> !o_ready)
        else $error("request taken with pending stage blocked");

endmodule

/* design/cdq_ram.sv */
// cdq_ram: single-write, single-read entry store with registered read data.
// Depends on cdq_pkg for the entry width.
module cdq_ram #(
    parameter int DEPTH = cdq_pkg::CDQ_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [cdq_pkg::ENTRY_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [cdq_pkg::ENTRY_W-1:0] o_rdata
);

    logic [cdq_pkg::ENTRY_W-1:0] r_mem [DEPTH];
    logic [cdq_pkg::ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: self-checking bench for circular_deque_core with a queue-fed driver and a monitor.
// Depends on cdq_pkg and the circular_deque_core RTL; the expected results come from a
// deque predictor kept inside the bench.
module tb_top;

    localparam int DQ_DEPTH      = cdq_pkg::CDQ_DEPTH;
    localparam int IDX_W         = $clog2(DQ_DEPTH);
    localparam int MAX_IDLE      = 6;
    localparam int HOLD_AT       = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int CALM_EVERY    = 50;
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [15:0] x_pos;
        logic [15:0] y_pos;
        logic [15:0] dir;
        logic [15:0] sprite;
    } t_slot;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    cdq_pkg::t_in_word  i_data  = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    cdq_pkg::t_out_word o_data;

    // Predictor state
    t_slot            slot_mem [DQ_DEPTH];
    logic [IDX_W-1:0] front_idx = '0;
    logic [IDX_W-1:0] back_idx  = '0;
    logic             vacant    = 1'b1;

    cdq_pkg::t_in_word  pending_reqs [$];
    cdq_pkg::t_out_word awaited [$];
    int        gen_fill   = 0;
    int        n_errors   = 0;
    int        sent_count = 0;
    int        send_gap   = 0;
    bit        send_calm  = 1'b0;
    int        taken      = 0;
    int        recv_stall = 0;
    int        recv_hold  = 0;
    bit        recv_calm  = 1'b0;

    circular_deque_core #(.DEPTH(DQ_DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int entries_held();
        if (vacant)
            return 0;
        return ((int'(back_idx) + DQ_DEPTH - int'(front_idx)) % DQ_DEPTH) + 1;
    endfunction

    task automatic predict_result(input cdq_pkg::t_in_word w,
                                  output cdq_pkg::t_out_word r);
        t_slot            ent;
        t_slot            got;
        cdq_pkg::t_status st;
        ent = {w.in_x_pos, w.in_y_pos, w.in_dir, w.in_sprite};
        got = '0;
        st  = cdq_pkg::ST_DONE;
        case (w.mode)
            cdq_pkg::MODE_INS_FRONT, cdq_pkg::MODE_INS_REAR: begin
                if (entries_held() == DQ_DEPTH) begin
                    st = cdq_pkg::ST_FULL;
                end else if (vacant) begin
                    // first word after empty always lands at index 0
                    front_idx   = '0;
                    back_idx    = '0;
                    vacant      = 1'b0;
                    slot_mem[0] = ent;
                end else if (w.mode == cdq_pkg::MODE_INS_FRONT) begin
                    front_idx = (front_idx == '0) ? IDX_W'(DQ_DEPTH - 1) : front_idx - 1'b1;
                    slot_mem[front_idx] = ent;
                end else begin
                    back_idx = (back_idx == IDX_W'(DQ_DEPTH - 1)) ? '0 : back_idx + 1'b1;
                    slot_mem[back_idx] = ent;
                end
            end
            cdq_pkg::MODE_REM_FRONT, cdq_pkg::MODE_REM_REAR, cdq_pkg::MODE_PEEK: begin
                if (vacant) begin
                    st = cdq_pkg::ST_EMPTY;
                end else if (w.mode == cdq_pkg::MODE_PEEK) begin
                    got = slot_mem[front_idx];
                end else if (w.mode == cdq_pkg::MODE_REM_FRONT) begin
                    got = slot_mem[front_idx];
                    if (front_idx == back_idx)
                        vacant = 1'b1;
                    else
                        front_idx = (front_idx == IDX_W'(DQ_DEPTH - 1)) ? '0 : front_idx + 1'b1;
                end else begin
                    got = slot_mem[back_idx];
                    if (front_idx == back_idx)
                        vacant = 1'b1;
                    else
                        back_idx = (back_idx == '0) ? IDX_W'(DQ_DEPTH - 1) : back_idx - 1'b1;
                end
            end
            default: ;
        endcase
        r.out_x_pos  = got.x_pos;
        r.out_y_pos  = got.y_pos;
        r.out_dir    = got.dir;
        r.out_sprite = got.sprite;
        r.status     = st;
        r.is_empty   = vacant;
        r.is_full    = (entries_held() == DQ_DEPTH);
        r.fill_count = cdq_pkg::FILL_W'(entries_held());
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        n_errors++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
    endtask

    // Stimulus generation; gen_fill shadows the occupancy to steer the mix
    task automatic queue_req(input logic [2:0] m, input t_slot v);
        cdq_pkg::t_in_word w;
        w.mode      = m;
        w.in_x_pos  = v.x_pos;
        w.in_y_pos  = v.y_pos;
        w.in_dir    = v.dir;
        w.in_sprite = v.sprite;
        pending_reqs.push_back(w);
        case (m)
            cdq_pkg::MODE_INS_FRONT, cdq_pkg::MODE_INS_REAR:
                if (gen_fill < DQ_DEPTH) gen_fill++;
            cdq_pkg::MODE_REM_FRONT, cdq_pkg::MODE_REM_REAR:
                if (gen_fill > 0) gen_fill--;
            default: ;
        endcase
    endtask

    function automatic t_slot rand_slot();
        return t_slot'({$urandom(), $urandom()});
    endfunction

    task automatic queue_random(input int ins_pct, input int rem_pct);
        int         roll;
        logic [2:0] m;
        roll = $urandom_range(0, 99);
        if (roll < ins_pct)
            m = $urandom_range(0, 1) ? cdq_pkg::MODE_INS_REAR : cdq_pkg::MODE_INS_FRONT;
        else if (roll < ins_pct + rem_pct)
            m = $urandom_range(0, 1) ? cdq_pkg::MODE_REM_REAR : cdq_pkg::MODE_REM_FRONT;
        else if (roll < 98)
            m = cdq_pkg::MODE_PEEK;
        else
            m = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        queue_req(m, rand_slot());
    endtask

    // Driver: next word goes out once the current one is taken and the gap has run out
    always @(posedge i_clk) begin : drv
        cdq_pkg::t_out_word r;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predict_result(i_data, r);
                awaited.push_back(r);
                sent_count++;
                if (sent_count % CALM_EVERY == 0)
                    send_calm = ($urandom_range(0, 2) == 0);
                send_gap = send_calm ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    i_data  <= pending_reqs.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure, with one long hold-off so the input side backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                taken++;
                if (taken % CALM_EVERY == 0)
                    recv_calm = ($urandom_range(0, 2) == 0);
                recv_stall = recv_calm ? 0 : $urandom_range(0, MAX_IDLE);
                if (taken == HOLD_AT)
                    recv_hold = HOLD_CYCLES;
            end
            if (recv_hold > 0) begin
                recv_hold--;
                i_ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : mon
        cdq_pkg::t_out_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("result word %h with none expected", o_data));
            end else begin
                want = awaited.pop_front();
                check_field("out_x_pos", o_data.out_x_pos, want.out_x_pos);
                check_field("out_y_pos", o_data.out_y_pos, want.out_y_pos);
                check_field("out_dir", o_data.out_dir, want.out_dir);
                check_field("out_sprite", o_data.out_sprite, want.out_sprite);
                check_field("status", 16'(o_data.status), 16'(want.status));
                check_field("is_empty", 16'(o_data.is_empty), 16'(want.is_empty));
                check_field("is_full", 16'(o_data.is_full), 16'(want.is_full));
                check_field("fill_count", 16'(o_data.fill_count), 16'(want.fill_count));
            end
        end
    end

    initial begin
        // empty deque: removes, peek and spare modes
        queue_req(cdq_pkg::MODE_REM_FRONT, rand_slot());
        queue_req(cdq_pkg::MODE_REM_REAR, rand_slot());
        queue_req(cdq_pkg::MODE_PEEK, rand_slot());
        queue_req(MODE_SPARE_LO, rand_slot());
        queue_req(3'd6, rand_slot());
        queue_req(MODE_SPARE_HI, rand_slot());
        // single word in and out again, all ones then all zeros
        queue_req(cdq_pkg::MODE_INS_REAR, '1);
        queue_req(cdq_pkg::MODE_PEEK, '0);
        queue_req(cdq_pkg::MODE_REM_REAR, '1);
        queue_req(cdq_pkg::MODE_INS_FRONT, '0);
        // front insert wraps the head below index 0
        queue_req(cdq_pkg::MODE_INS_FRONT, {16'hA5A5, 16'h5A5A, 16'hFFFF, 16'h0001});
        queue_req(cdq_pkg::MODE_INS_REAR, {16'h5A5A, 16'hA5A5, 16'h8000, 16'h7FFF});
        queue_req(cdq_pkg::MODE_PEEK, rand_slot());
        queue_req(cdq_pkg::MODE_REM_FRONT, rand_slot());
        queue_req(cdq_pkg::MODE_REM_REAR, rand_slot());
        queue_req(MODE_SPARE_HI, rand_slot());
        queue_req(cdq_pkg::MODE_REM_FRONT, rand_slot());
        queue_req(cdq_pkg::MODE_INS_FRONT, rand_slot());
        queue_req(cdq_pkg::MODE_REM_FRONT, rand_slot());

        // hover near empty, then fill to the brim, work at full, then drain a little
        repeat (120) queue_random(45, 40);
        while (gen_fill < DQ_DEPTH)
            queue_random(93, 3);
        repeat (40) queue_random(55, 30);
        repeat (60) queue_random(30, 60);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(negedge i_clk);
        while (pending_reqs.size() != 0 || i_valid || awaited.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TIMEOUT: %0d words still expected", awaited.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
